### src/fdt_pkg.sv
// Shared types, widths and constants for the frequency drift and throttle detector.
package fdt_pkg;

   localparam int WINDOW_LEN_DEFAULT = 8;

   localparam int TS_W        = 32;
   localparam int RATE_W      = 24;
   localparam int RATIO_W     = 16;
   localparam int INTERVAL_W  = 16;
   localparam int LIMIT_W     = 16;
   localparam int FRAC_W      = 14;
   localparam int CV_SCALE_W  = 32;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_NOMINAL_RATE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_INTERVAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THROTTLE_RATIO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CV_LIMIT       = 2'd3;

   localparam logic [RATE_W-1:0]     NOMINAL_RESET  = 24'd1;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;
   localparam logic [RATIO_W-1:0]    THROTTLE_RESET = 16'd14746;
   localparam logic [LIMIT_W-1:0]    CV_LIMIT_RESET = 16'd2621;
   localparam logic [RATIO_W-1:0]    RATIO_ONE      = 16'd16384;

   // Window count width, multiplier operand width and product width.
   function automatic int count_width(input int win);
      return $clog2(win + 1);
   endfunction

   function automatic int mpl_width(input int win);
      return 2 * RATIO_W + 2 * count_width(win);
   endfunction

   function automatic int prod_width(input int win);
      return 2 * RATIO_W + 3 * count_width(win) + CV_SCALE_W;
   endfunction

   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] quotient;
   } fdt_div_rsp_type;

   typedef struct packed {
      logic               start;
      logic [RATIO_W-1:0] ratio;
   } fdt_win_req_type;

   typedef struct packed {
      logic done;
      logic oscillating;
   } fdt_win_rsp_type;

endpackage

### src/fdt_div.sv
// Bit-serial restoring divider for the saturated Q2.14 ratio.
module fdt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fdt_pkg::RATE_W-1:0]  dividend,
   input  logic [fdt_pkg::RATE_W-1:0]  divisor,
   output fdt_pkg::fdt_div_rsp_type    rsp
);
   import fdt_pkg::*;

   localparam int STEPS = RATE_W + FRAC_W;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RATE_W-1:0] dvd_ff, dvd_in;
   logic [RATE_W-1:0] div_ff, div_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATIO_W-1:0] q_ff, q_in;
   logic              ovf_ff, ovf_in;
   logic [RATE_W:0]   shifted;
   logic [RATE_W:0]   diff;
   logic              geq;

   always_comb begin
      shifted = {rem_ff, dvd_ff[RATE_W-1]};
      diff    = shifted - {1'b0, div_ff};
      geq     = shifted >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
         ovf_in = 1'b0;
         cnt_in = '0;
         if (divisor == '0) begin
            q_in    = RATIO_ONE;
            done_in = 1'b1;
         end else begin
            q_in    = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RATE_W-2:0], 1'b0};
         rem_in = geq ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
         q_in   = {q_ff[RATIO_W-2:0], geq};
         ovf_in = ovf_ff | q_ff[RATIO_W-1];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = ovf_ff ? '1 : q_ff;

endmodule

### src/fdt_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, stops when the rest is zero.
module fdt_mul #(
   parameter int WINDOW_LEN = fdt_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              start,
   input  logic [fdt_pkg::prod_width(WINDOW_LEN)-1:0]        mcand,
   input  logic [fdt_pkg::mpl_width(WINDOW_LEN)-1:0]         mpl,
   output logic                                              done,
   output logic [fdt_pkg::prod_width(WINDOW_LEN)-1:0]        prod
);
   import fdt_pkg::*;

   localparam int PW  = prod_width(WINDOW_LEN);
   localparam int MPW = mpl_width(WINDOW_LEN);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [PW-1:0]  acc_ff, acc_in;
   logic [PW-1:0]  mc_ff, mc_in;
   logic [MPW-1:0] mp_ff, mp_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         mc_in   = mcand;
         mp_in   = mpl;
      end else if (busy_ff) begin
         acc_in = mp_ff[0] ? acc_ff + mc_ff : acc_ff;
         mc_in  = {mc_ff[PW-2:0], 1'b0};
         mp_in  = {1'b0, mp_ff[MPW-1:1]};
         if (mp_in == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### src/fdt_window.sv
// Ratio ring with running sums and the sequenced coefficient of variation test.
module fdt_window #(
   parameter int WINDOW_LEN = fdt_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fdt_pkg::fdt_win_req_type     req,
   input  logic [fdt_pkg::LIMIT_W-1:0]  cv_limit,
   output fdt_pkg::fdt_win_rsp_type     rsp
);
   import fdt_pkg::*;

   localparam int NW  = count_width(WINDOW_LEN);
   localparam int IW  = $clog2(WINDOW_LEN);
   localparam int S1W = RATIO_W + NW;
   localparam int S2W = 2 * RATIO_W + NW;
   localparam int BW  = 2 * RATIO_W + 2 * NW;
   localparam int TW  = 2 * RATIO_W + 3 * NW;
   localparam int EW  = 2 * LIMIT_W + NW;
   localparam int PW  = prod_width(WINDOW_LEN);
   localparam int MPW = mpl_width(WINDOW_LEN);

   localparam logic [IW-1:0] LAST_INDEX = IW'(WINDOW_LEN - 1);
   localparam logic [NW-1:0] FULL_COUNT = NW'(WINDOW_LEN);

   localparam logic [1:0] W_IDLE  = 2'd0;
   localparam logic [1:0] W_ISSUE = 2'd1;
   localparam logic [1:0] W_WAIT  = 2'd2;

   localparam logic [2:0] OP_SQ_NEW = 3'd0;
   localparam logic [2:0] OP_SQ_OLD = 3'd1;
   localparam logic [2:0] OP_N_S2   = 3'd2;
   localparam logic [2:0] OP_S1_SQ  = 3'd3;
   localparam logic [2:0] OP_D_N    = 3'd4;
   localparam logic [2:0] OP_LIM_SQ = 3'd5;
   localparam logic [2:0] OP_E_N1   = 3'd6;
   localparam logic [2:0] OP_FINAL  = 3'd7;

   logic [RATIO_W-1:0] ring_mem [WINDOW_LEN];
   logic [RATIO_W-1:0] rd_ff;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               full_ff, full_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [S1W-1:0]     s1_ff, s1_in;
   logic [S2W-1:0]     s2_ff, s2_in;
   fdt_win_rsp_type    rsp_ff, rsp_in;

   logic [RATIO_W-1:0] new_ff, new_in;
   logic [RATIO_W-1:0] old_ff, old_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [BW-1:0]      b_ff, b_in;
   logic [EW-1:0]      e_ff, e_in;

   logic [IW-1:0]      idx_next;
   logic               full_next;
   logic [S1W-1:0]     s1_upd;
   logic [S2W-1:0]     s2_upd;
   logic               push;
   logic               mul_start;
   logic [PW-1:0]      mul_mcand;
   logic [MPW-1:0]     mul_mpl;
   logic               mul_done;
   logic [PW-1:0]      mul_prod;

   fdt_mul #(.WINDOW_LEN(WINDOW_LEN)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .mcand (mul_mcand),
      .mpl   (mul_mpl),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign push      = (state_ff == W_IDLE) && req.start;
   assign mul_start = (state_ff == W_ISSUE);
   assign idx_next  = (idx_ff == LAST_INDEX) ? '0 : idx_ff + 1'b1;
   assign full_next = full_ff | (idx_ff == LAST_INDEX);
   assign s1_upd    = s1_ff + S1W'(new_ff) - S1W'(old_ff);
   assign s2_upd    = s2_ff + S2W'(t_ff) - S2W'(mul_prod);

   always_comb begin
      case (op_ff)
         OP_SQ_NEW: begin
            mul_mcand = PW'(new_ff);
            mul_mpl   = MPW'(new_ff);
         end
         OP_SQ_OLD: begin
            mul_mcand = PW'(old_ff);
            mul_mpl   = MPW'(old_ff);
         end
         OP_N_S2: begin
            mul_mcand = PW'(s2_ff);
            mul_mpl   = MPW'(n_ff);
         end
         OP_S1_SQ: begin
            mul_mcand = PW'(s1_ff);
            mul_mpl   = MPW'(s1_ff);
         end
         OP_D_N: begin
            mul_mcand = PW'(t_ff);
            mul_mpl   = MPW'(n_ff);
         end
         OP_LIM_SQ: begin
            mul_mcand = PW'(cv_limit);
            mul_mpl   = MPW'(cv_limit);
         end
         OP_E_N1: begin
            mul_mcand = PW'(e_ff);
            mul_mpl   = MPW'(n_ff - NW'(1));
         end
         OP_FINAL: begin
            mul_mcand = PW'(b_ff);
            mul_mpl   = MPW'(e_ff);
         end
         default: begin
            mul_mcand = '0;
            mul_mpl   = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      full_in  = full_ff;
      n_in     = n_ff;
      s1_in    = s1_ff;
      s2_in    = s2_ff;
      rsp_in   = '0;
      new_in   = new_ff;
      old_in   = old_ff;
      t_in     = t_ff;
      b_in     = b_ff;
      e_in     = e_ff;
      case (state_ff)
         W_IDLE: begin
            if (req.start) begin
               new_in   = req.ratio;
               old_in   = full_ff ? rd_ff : '0;
               idx_in   = idx_next;
               full_in  = full_next;
               n_in     = full_next ? FULL_COUNT : NW'(idx_next);
               op_in    = OP_SQ_NEW;
               state_in = W_ISSUE;
            end
         end
         W_ISSUE: begin
            state_in = W_WAIT;
         end
         W_WAIT: begin
            if (mul_done) begin
               op_in    = op_ff + 1'b1;
               state_in = W_ISSUE;
               case (op_ff)
                  OP_SQ_NEW: t_in = TW'(mul_prod);
                  OP_SQ_OLD: begin
                     s1_in = s1_upd;
                     s2_in = s2_upd;
                     // too few entries or an all-zero window: no oscillation
                     if ((n_ff < NW'(2)) || (s1_upd == '0)) begin
                        rsp_in.done = 1'b1;
                        state_in    = W_IDLE;
                     end
                  end
                  OP_N_S2: t_in = TW'(mul_prod);
                  OP_S1_SQ: begin
                     b_in = BW'(mul_prod);
                     t_in = t_ff - TW'(mul_prod);
                  end
                  OP_D_N:    t_in = TW'(mul_prod);
                  OP_LIM_SQ: e_in = EW'(mul_prod);
                  OP_E_N1:   e_in = EW'(mul_prod);
                  OP_FINAL: begin
                     rsp_in.done        = 1'b1;
                     rsp_in.oscillating = {t_ff, {CV_SCALE_W{1'b0}}} > mul_prod;
                     state_in           = W_IDLE;
                  end
                  default: state_in = W_IDLE;
               endcase
            end
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         op_ff    <= OP_SQ_NEW;
         idx_ff   <= '0;
         full_ff  <= 1'b0;
         n_ff     <= '0;
         s1_ff    <= '0;
         s2_ff    <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
         full_ff  <= full_in;
         n_ff     <= n_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff <= new_in;
      old_ff <= old_in;
      t_ff   <= t_in;
      b_ff   <= b_in;
      e_ff   <= e_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ring_mem[idx_ff] <= req.ratio;
      end
      rd_ff <= ring_mem[idx_ff];
   end

   assign rsp = rsp_ff;

endmodule

### src/freq_drift_throttle_detector_top.sv
// Frequency drift and throttle detector: top level with channels, registers and sequencing.
//
// Request channel (req_): a timestamped rate measurement; an item is taken when req_valid
// is high and req_stall low. Response channel (rsp_): one result item per request item,
// taken when rsp_valid is high and rsp_stall low. csr_ writes one of four registers.
// An item arriving before the probe interval has elapsed is answered with the held
// results and rsp_accepted low; rsp_valid rises once ST_EMIT loads the output register.
// An accepted item runs a bit-serial divider (one quotient bit a cycle) and then up to
// eight products on one shared shift-and-add multiplier, one multiplier bit a cycle;
// operand widths set most of the time. One item is in work at a time; req_stall is
// high from acceptance until the result is placed in the output register. A result
// waiting under rsp_stall holds the output register; the block may take the next item
// meanwhile and holds its result until the output register frees.
// Reset (synchronous, active high) restores the register defaults, empties the window
// and marks that no probe has been taken yet, so the first item is always accepted.
module freq_drift_throttle_detector_top #(
   parameter int WINDOW_LEN = fdt_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fdt_pkg::TS_W-1:0]         req_timestamp_ms,
   input  logic [fdt_pkg::RATE_W-1:0]       req_measured_rate,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fdt_pkg::RATIO_W-1:0]      rsp_ratio,
   output logic [fdt_pkg::RATE_W-1:0]       rsp_current_rate,
   output logic                             rsp_throttled,
   output logic                             rsp_oscillating,
   output logic                             rsp_accepted,
   input  logic                             csr_write,
   input  logic [fdt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fdt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fdt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_WIN  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [RATE_W-1:0]     nominal_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [RATIO_W-1:0]    throttle_ff;
   logic [LIMIT_W-1:0]    cv_limit_ff;

   logic [1:0]         state_ff, state_in;
   logic               have_probe_ff, have_probe_in;
   logic [TS_W-1:0]    last_probe_ff, last_probe_in;
   logic [RATIO_W-1:0] held_ratio_ff, held_ratio_in;
   logic [RATE_W-1:0]  held_rate_ff, held_rate_in;
   logic               held_thr_ff, held_thr_in;
   logic               held_osc_ff, held_osc_in;
   logic               acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [TS_W-1:0]    ts_ff, ts_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [RATIO_W-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic [RATE_W-1:0]  rsp_rate_ff, rsp_rate_in;
   logic               rsp_thr_ff, rsp_thr_in;
   logic               rsp_osc_ff, rsp_osc_in;
   logic               rsp_acc_ff, rsp_acc_in;

   logic               take_in;
   logic [TS_W-1:0]    elapsed;
   logic               take_probe;
   logic               div_start;
   fdt_div_rsp_type    div_rsp;
   fdt_win_req_type    win_req;
   fdt_win_rsp_type    win_rsp;
   logic               out_free;

   fdt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_measured_rate),
      .divisor  (nominal_ff),
      .rsp      (div_rsp)
   );

   fdt_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
      .clock    (clock),
      .reset    (reset),
      .req      (win_req),
      .cv_limit (cv_limit_ff),
      .rsp      (win_rsp)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign take_in    = req_valid && !req_stall;
   assign elapsed    = req_timestamp_ms - last_probe_ff;
   assign take_probe = !have_probe_ff || (elapsed >= TS_W'(interval_ff));
   assign div_start  = take_in && take_probe;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign win_req.start = (state_ff == ST_DIV) && div_rsp.done;
   assign win_req.ratio = div_rsp.quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff  <= NOMINAL_RESET;
         interval_ff <= INTERVAL_RESET;
         throttle_ff <= THROTTLE_RESET;
         cv_limit_ff <= CV_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NOMINAL_RATE:   nominal_ff  <= csr_wdata;
            CSR_PROBE_INTERVAL: interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_THROTTLE_RATIO: throttle_ff <= csr_wdata[RATIO_W-1:0];
            CSR_CV_LIMIT:       cv_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      have_probe_in = have_probe_ff;
      last_probe_in = last_probe_ff;
      held_ratio_in = held_ratio_ff;
      held_rate_in  = held_rate_ff;
      held_thr_in   = held_thr_ff;
      held_osc_in   = held_osc_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ts_in         = ts_ff;
      rate_in       = rate_ff;
      ratio_in      = ratio_ff;
      rsp_ratio_in  = rsp_ratio_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_thr_in    = rsp_thr_ff;
      rsp_osc_in    = rsp_osc_ff;
      rsp_acc_in    = rsp_acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_in) begin
               if (take_probe) begin
                  ts_in    = req_timestamp_ms;
                  rate_in  = req_measured_rate;
                  state_in = ST_DIV;
               end else begin
                  acc_in   = 1'b0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               ratio_in = div_rsp.quotient;
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            if (win_rsp.done) begin
               held_ratio_in = ratio_ff;
               held_rate_in  = rate_ff;
               held_thr_in   = ratio_ff < throttle_ff;
               held_osc_in   = win_rsp.oscillating;
               last_probe_in = ts_ff;
               have_probe_in = 1'b1;
               acc_in        = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ratio_in = held_ratio_ff;
               rsp_rate_in  = held_rate_ff;
               rsp_thr_in   = held_thr_ff;
               rsp_osc_in   = held_osc_ff;
               rsp_acc_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_probe_ff <= 1'b0;
         last_probe_ff <= '0;
         held_ratio_ff <= RATIO_ONE;
         held_rate_ff  <= '0;
         held_thr_ff   <= 1'b0;
         held_osc_ff   <= 1'b0;
         acc_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_probe_ff <= have_probe_in;
         last_probe_ff <= last_probe_in;
         held_ratio_ff <= held_ratio_in;
         held_rate_ff  <= held_rate_in;
         held_thr_ff   <= held_thr_in;
         held_osc_ff   <= held_osc_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff        <= ts_in;
      rate_ff      <= rate_in;
      ratio_ff     <= ratio_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_thr_ff   <= rsp_thr_in;
      rsp_osc_ff   <= rsp_osc_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ratio        = rsp_ratio_ff;
   assign rsp_current_rate = rsp_rate_ff;
   assign rsp_throttled    = rsp_thr_ff;
   assign rsp_oscillating  = rsp_osc_ff;
   assign rsp_accepted     = rsp_acc_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      take_in |=> req_stall)
      else $error("item taken while another is in work");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its phase");

   a_win_done: assert property (@(posedge clock) disable iff (reset)
      win_rsp.done |-> (state_ff == ST_WIN))
      else $error("window test finished outside its phase");

   a_probe_seen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_acc_ff) |-> have_probe_ff)
      else $error("accepted result without a recorded probe");

endmodule

### bench/freq_drift_throttle_detector_top_test.sv
// Self-checking testbench for the frequency drift and throttle detector top level.
`timescale 1ns / 100ps

module freq_drift_throttle_detector_top_test;
   import fdt_pkg::*;

   localparam int WIN         = WINDOW_LEN_DEFAULT;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 800;

   typedef struct {
      logic [RATIO_W-1:0] ratio;
      logic [RATE_W-1:0]  rate;
      logic               throttled;
      logic               oscillating;
      logic               accepted;
   } probe_outcome_type;

   class throttle_tracker;
      logic [RATE_W-1:0]     nominal;
      logic [INTERVAL_W-1:0] interval;
      logic [RATIO_W-1:0]    throttle_level;
      logic [LIMIT_W-1:0]    cv_lim;
      logic [RATIO_W-1:0]    ring [WIN];
      int unsigned           fill_idx;
      bit                    full;
      logic [TS_W-1:0]       last_ts;
      bit                    have_probe;
      logic [RATIO_W-1:0]    held_ratio;
      logic [RATE_W-1:0]     held_rate;
      bit                    held_throttled;
      bit                    held_osc;
      probe_outcome_type     pending [$];
      int unsigned           errors, checked, taken, ignored, seen_thr, seen_osc, settings;

      function new();
         nominal        = NOMINAL_RESET;
         interval       = INTERVAL_RESET;
         throttle_level = THROTTLE_RESET;
         cv_lim         = CV_LIMIT_RESET;
         fill_idx       = 0;
         full           = 0;
         last_ts        = '0;
         have_probe     = 0;
         held_ratio     = RATIO_ONE;
         held_rate      = '0;
         held_throttled = 0;
         held_osc       = 0;
      endfunction

      function void write_reg(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_NOMINAL_RATE:   nominal = data[RATE_W-1:0];
            CSR_PROBE_INTERVAL: interval = data[INTERVAL_W-1:0];
            CSR_THROTTLE_RATIO: throttle_level = data[RATIO_W-1:0];
            CSR_CV_LIMIT:       cv_lim = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // exact CV test: (n*S2 - S1^2)*n*2^32 > lim^2*(n-1)*S1^2
      function bit window_swings();
         logic [127:0] s1, s2, v, n, sq, c, lhs, rhs;
         int cnt;
         cnt = full ? WIN : fill_idx;
         if (cnt < 2) return 0;
         s1 = '0;
         s2 = '0;
         for (int i = 0; i < cnt; i++) begin
            v = ring[i];
            s1 += v;
            s2 += v * v;
         end
         if (s1 == 0) return 0;
         n   = cnt;
         c   = cv_lim;
         sq  = s1 * s1;
         lhs = ((n * s2 - sq) * n) << 32;
         rhs = c * c * (n - 1) * sq;
         return lhs > rhs;
      endfunction

      function void take_probe(input logic [TS_W-1:0] ts, input logic [RATE_W-1:0] rate);
         logic [TS_W-1:0]   elapsed;
         logic [63:0]       r;
         probe_outcome_type o;
         elapsed    = ts - last_ts;
         o.accepted = !(have_probe && elapsed < interval);
         if (o.accepted) begin
            if (nominal == 0) begin
               r = RATIO_ONE;
            end else begin
               r = 64'(rate) << FRAC_W;
               r = r / nominal;
               if (r > 64'hFFFF) r = 64'hFFFF;
            end
            ring[fill_idx] = r[RATIO_W-1:0];
            fill_idx = (fill_idx + 1) % WIN;
            if (!full && fill_idx == 0) full = 1;
            held_throttled = r < throttle_level;
            held_osc       = window_swings();
            held_ratio     = r[RATIO_W-1:0];
            held_rate      = rate;
            last_ts        = ts;
            have_probe     = 1;
            taken++;
         end else begin
            ignored++;
         end
         o.ratio       = held_ratio;
         o.rate        = held_rate;
         o.throttled   = held_throttled;
         o.oscillating = held_osc;
         pending.push_back(o);
      endfunction

      task report(input string what);
         errors++;
         if (errors <= 50) $display("%0t ns mismatch: %s", $time, what);
      endtask

      task check_outcome(input probe_outcome_type got);
         probe_outcome_type want;
         if (pending.size() == 0) begin
            report($sformatf("result with no item outstanding (ratio %0d)", got.ratio));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.throttled === 1'b1) seen_thr++;
         if (got.oscillating === 1'b1) seen_osc++;
         if (got.ratio !== want.ratio)
            report($sformatf("ratio %0d, want %0d", got.ratio, want.ratio));
         if (got.rate !== want.rate)
            report($sformatf("current_rate %0d, want %0d", got.rate, want.rate));
         if (got.throttled !== want.throttled)
            report($sformatf("throttled %b, want %b", got.throttled, want.throttled));
         if (got.oscillating !== want.oscillating)
            report($sformatf("oscillating %b, want %b", got.oscillating, want.oscillating));
         if (got.accepted !== want.accepted)
            report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [TS_W-1:0]        req_timestamp_ms = '0;
   logic [RATE_W-1:0]      req_measured_rate = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [RATIO_W-1:0]     rsp_ratio;
   logic [RATE_W-1:0]      rsp_current_rate;
   logic                   rsp_throttled;
   logic                   rsp_oscillating;
   logic                   rsp_accepted;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   throttle_tracker tracker;
   bit              idle_on = 1'b1;
   int unsigned     hold_asks = 0;
   int unsigned     hold_done = 0;
   int unsigned     hold_left = 0;
   int unsigned     quiet = 0;

   freq_drift_throttle_detector_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_timestamp_ms  (req_timestamp_ms),
      .req_measured_rate (req_measured_rate),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ratio         (rsp_ratio),
      .rsp_current_rate  (rsp_current_rate),
      .rsp_throttled     (rsp_throttled),
      .rsp_oscillating   (rsp_oscillating),
      .rsp_accepted      (rsp_accepted),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check, then choose next stall
   always @(posedge clock) begin
      probe_outcome_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.ratio       = rsp_ratio;
         got.rate        = rsp_current_rate;
         got.throttled   = rsp_throttled;
         got.oscillating = rsp_oscillating;
         got.accepted    = rsp_accepted;
         tracker.check_outcome(got);
      end
      if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(99) < 38) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic offer_probe(input logic [TS_W-1:0] ts, input logic [RATE_W-1:0] rate);
      while (idle_on && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_timestamp_ms  <= ts;
      req_measured_rate <= rate;
      do @(posedge clock); while (req_stall);
      tracker.take_probe(ts, rate);
   endtask

   task automatic drain_outstanding();
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_regs(input logic [CSR_DATA_W-1:0] nom, input logic [CSR_DATA_W-1:0] intv,
                           input logic [CSR_DATA_W-1:0] thr, input logic [CSR_DATA_W-1:0] cvl);
      logic [CSR_DATA_W-1:0]  vals [4];
      logic [CSR_INDEX_W-1:0] idx [4];
      vals = '{nom, intv, thr, cvl};
      idx  = '{CSR_NOMINAL_RATE, CSR_PROBE_INTERVAL, CSR_THROTTLE_RATIO, CSR_CV_LIMIT};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         tracker.write_reg(idx[i], vals[i]);
      end
      csr_write <= 1'b0;
      tracker.settings++;
   endtask

   initial begin
      int unsigned      nom, intv, thr, cvl, jit, base_taken;
      int               off;
      longint           r;
      logic [TS_W-1:0]  ts;
      logic [RATE_W-1:0] rate;

      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register defaults: first item, early item, saturation, timestamp wrap
      offer_probe(32'h0000_0000, 24'd0);
      offer_probe(32'h0000_0063, 24'hFFFFFF);
      offer_probe(32'h0000_0064, 24'hFFFFFF);
      offer_probe(32'hFFFF_FFFF, 24'd1);
      offer_probe(32'h0000_0062, 24'd5);
      offer_probe(32'h0000_0063, 24'd2);
      drain_outstanding();

      // zero nominal rate, zero interval, zero CV limit
      set_regs(24'd0, 24'd0, 24'h00FFFF, 24'd0);
      offer_probe(32'h0000_0063, 24'd12345);
      offer_probe(32'h0000_0063, 24'd0);
      offer_probe(32'hAAAA_5555, 24'hFFFFFF);
      drain_outstanding();

      // top of nominal, interval and CV limit; upper write bits set on interval and throttle, throttle zero
      set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFF0000, 24'h00FFFF);
      offer_probe(32'h5555_AAAA, 24'hFFFFFF);
      offer_probe(32'h5556_AAA9, 24'd0);
      offer_probe(32'h5557_AAA7, 24'd7);
      offer_probe(32'h5557_AAA8, 24'd123456);
      drain_outstanding();

      // steady window then a drop below threshold
      set_regs(24'd16384, 24'd10, 24'd16384, {8'hA5, CV_LIMIT_RESET});
      for (int i = 0; i < 5; i++)
         offer_probe(tracker.last_ts + 32'd10, (i == 4) ? 24'd8000 : 24'd16384);
      drain_outstanding();

      for (int p = 0; p < 8; p++) begin
         nom  = ($urandom_range(3) == 0) ? $urandom_range(1, 24'hFFFFFF)
                                        : $urandom_range(1000, 200000);
         intv = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 200);
         thr  = ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                        : $urandom_range(12000, 17000);
         cvl  = ($urandom_range(4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12000);
         jit  = $urandom_range(0, 30);
         set_regs(24'(nom), {8'($urandom), 16'(intv)}, {8'($urandom), 16'(thr)},
                  {8'($urandom), 16'(cvl)});
         idle_on = (p != 2);
         if (p == 5) hold_asks <= hold_asks + 1;
         base_taken = tracker.taken;
         while (tracker.taken - base_taken < 50) begin
            case ($urandom_range(19))
               0, 1:    ts = tracker.last_ts + $urandom_range(0, tracker.interval);
               2:       ts = $urandom;
               default: ts = tracker.last_ts + tracker.interval + $urandom_range(0, 50);
            endcase
            off = int'($urandom_range(0, 2 * jit)) - int'(jit);
            r   = longint'(nom) * (100 + off) / 100;
            if (r > 64'hFFFFFF) r = 64'hFFFFFF;
            rate = ($urandom_range(9) == 0) ? 24'($urandom) : r[RATE_W-1:0];
            offer_probe(ts, rate);
         end
         drain_outstanding();
      end

      idle_on = 1'b0;
      repeat (200) @(posedge clock);

      $display("Run covered %0d probes taken and %0d ignored, %0d results checked",
               tracker.taken, tracker.ignored, tracker.checked);
      $display("over %0d register settings; throttled seen %0d times, oscillating %0d times",
               tracker.settings, tracker.seen_thr, tracker.seen_osc);
      if (tracker.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### freq_drift_throttle_detector_top.f
src/fdt_pkg.sv
src/fdt_div.sv
src/fdt_mul.sv
src/fdt_window.sv
src/freq_drift_throttle_detector_top.sv
bench/freq_drift_throttle_detector_top_test.sv
